// ----- sv/tptr_pkg.sv -----
// Shared constants, widths and controller/datapath interface types for the
// TLB and page table translator. No dependencies.
package tptr_pkg;

  localparam int TLB_ENTRIES = 16;
  localparam int PAGE_COUNT  = 256;
  localparam int PAGE_BYTES  = 256;

  localparam int ADDR_W    = 16;
  localparam int EV_PAGE_W = 8;
  localparam int PAGE_W    = $clog2(PAGE_COUNT);
  localparam int OFF_W     = $clog2(PAGE_BYTES);
  localparam int TLB_IDX_W = $clog2(TLB_ENTRIES);
  localparam int EXT_W     = ADDR_W + PAGE_W + OFF_W;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic lookup;
    logic resolve;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_room;
  } status_t;

endpackage

// ----- sv/tlb_page_table_translator.sv -----
// Top level of the TLB and page table translator; joins tptr_ctrl and
// tptr_datapath. Depends on tptr_pkg.
//
// Each item is a 16-bit logical address whose upper byte is the page and
// lower byte the offset. The page is compared against all 16 TLB entries
// in parallel, the lowest valid match winning; on a miss the page table is
// consulted, and a non-resident page takes the next frame in FIFO order,
// displacing whatever page held that frame. Every miss refills the TLB in
// FIFO order. TLB entries of a displaced page are kept, so a later hit on
// such a page returns its old, reused frame. An item goes through the steps
// capture of the address, TLB compare with the registered reads of the page
// table and FIFO slot memories, and resolve of the result with the write back
// of the tables. The next item is accepted in the cycle after the result is
// loaded into the output register, so the block takes no new item while one
// is in work; a result left waiting holds the resolve step. The page table
// residency and TLB valid bits are flip-flops cleared by reset, so no
// clearing pass is needed and the block is ready right out of reset.
module tlb_page_table_translator (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [tptr_pkg::ADDR_W-1:0]    logical_address_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [tptr_pkg::ADDR_W-1:0]    physical_address_o,
  output logic                           tlb_hit_o,
  output logic                           page_fault_o,
  output logic                           evicted_valid_o,
  output logic [tptr_pkg::EV_PAGE_W-1:0] evicted_page_o
);
  import tptr_pkg::*;

  cmd_t    cmd;
  status_t status;

  // The controller only sequences; all state of the translation lives in
  // the datapath.
  tptr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  tptr_datapath u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .status_o           (status),
    .logical_address_i  (logical_address_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .physical_address_o (physical_address_o),
    .tlb_hit_o          (tlb_hit_o),
    .page_fault_o       (page_fault_o),
    .evicted_valid_o    (evicted_valid_o),
    .evicted_page_o     (evicted_page_o)
  );

endmodule

// ----- sv/tptr_ctrl.sv -----
// Sequencing state machine of the translator: capture, lookup, resolve.
// Depends on tptr_pkg for the command and status types.
module tptr_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  tptr_pkg::status_t status_i,
  output tptr_pkg::cmd_t    cmd_o
);
  import tptr_pkg::*;

  localparam logic [1:0] StIdle    = 2'd0;
  localparam logic [1:0] StLook    = 2'd1;
  localparam logic [1:0] StResolve = 2'd2;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d       = state_q;
    cmd_o.capture = 1'b0;
    cmd_o.lookup  = 1'b0;
    cmd_o.resolve = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = StLook;
        end
      end
      StLook: begin
        cmd_o.lookup = 1'b1;
        state_d      = StResolve;
      end
      StResolve: begin
        // Wait here until the output register can take the result.
        if (status_i.out_room) begin
          cmd_o.resolve = 1'b1;
          state_d       = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  assign in_stall_o = (state_q != StIdle);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- sv/tptr_datapath.sv -----
// Datapath of the translator: TLB, page table, FIFO slot table and result
// register. Depends on tptr_pkg for constants and interface types.
module tptr_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  tptr_pkg::cmd_t                      cmd_i,
  output tptr_pkg::status_t                   status_o,
  input  logic [tptr_pkg::ADDR_W-1:0]         logical_address_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [tptr_pkg::ADDR_W-1:0]         physical_address_o,
  output logic                                tlb_hit_o,
  output logic                                page_fault_o,
  output logic                                evicted_valid_o,
  output logic [tptr_pkg::EV_PAGE_W-1:0]      evicted_page_o
);
  import tptr_pkg::*;

  logic [ADDR_W-1:0]    addr_q;
  logic [EXT_W-1:0]     addr_ext;
  logic [PAGE_W-1:0]    page;
  logic [OFF_W-1:0]     offset;

  logic [TLB_ENTRIES-1:0] tlb_valid_q;
  logic [PAGE_W-1:0]      tlb_page_q  [TLB_ENTRIES];
  logic [PAGE_W-1:0]      tlb_frame_q [TLB_ENTRIES];
  logic [TLB_IDX_W-1:0]   tlb_fill_q;

  logic                 look_hit;
  logic [PAGE_W-1:0]    look_frame;
  logic                 hit_q;
  logic [PAGE_W-1:0]    hit_frame_q;

  logic [PAGE_COUNT-1:0] page_present_q;
  logic [PAGE_W-1:0]     page_frame_mem [PAGE_COUNT];
  logic [PAGE_W-1:0]     slot_page_mem  [PAGE_COUNT];
  logic [PAGE_W-1:0]     frame_rd_q;
  logic [PAGE_W-1:0]     slot_rd_q;

  logic [PAGE_W-1:0]    fault_ptr_q;
  logic                 wrapped_q;

  logic                 present;
  logic                 miss;
  logic                 fault;
  logic                 ev_valid;
  logic [PAGE_W-1:0]    ev_page;
  logic [PAGE_W-1:0]    frame;
  logic                 fault_wr;

  assign addr_ext = EXT_W'(addr_q);
  assign page     = addr_ext[OFF_W +: PAGE_W];
  assign offset   = addr_ext[OFF_W-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      addr_q <= logical_address_i;
    end
  end

  // Lowest valid matching entry wins.
  always_comb begin
    look_hit   = 1'b0;
    look_frame = '0;
    for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
      if (tlb_valid_q[i] && (tlb_page_q[i] == page)) begin
        look_hit   = 1'b1;
        look_frame = tlb_frame_q[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.lookup) begin
      hit_q       <= look_hit;
      hit_frame_q <= look_frame;
    end
  end

  // Resolve: decide hit, page table hit or fault from the registered reads.
  assign present  = page_present_q[page];
  assign miss     = !hit_q;
  assign fault    = miss && !present;
  assign ev_valid = fault && wrapped_q;
  assign ev_page  = ev_valid ? slot_rd_q : '0;
  assign fault_wr = cmd_i.resolve && fault;

  always_comb begin
    priority if (hit_q) begin
      frame = hit_frame_q;
    end else if (present) begin
      frame = frame_rd_q;
    end else begin
      frame = fault_ptr_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.lookup) begin
      frame_rd_q <= page_frame_mem[page];
    end
    if (fault_wr) begin
      page_frame_mem[page] <= fault_ptr_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.lookup) begin
      slot_rd_q <= slot_page_mem[fault_ptr_q];
    end
    if (fault_wr) begin
      slot_page_mem[fault_ptr_q] <= page;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      page_present_q <= '0;
      fault_ptr_q    <= '0;
      wrapped_q      <= 1'b0;
    end else if (fault_wr) begin
      page_present_q[page] <= 1'b1;
      if (ev_valid) begin
        page_present_q[ev_page] <= 1'b0;
      end
      if (fault_ptr_q == PAGE_W'(PAGE_COUNT - 1)) begin
        fault_ptr_q <= '0;
        wrapped_q   <= 1'b1;
      end else begin
        fault_ptr_q <= fault_ptr_q + PAGE_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tlb_valid_q <= '0;
      tlb_fill_q  <= '0;
    end else if (cmd_i.resolve && miss) begin
      tlb_valid_q[tlb_fill_q] <= 1'b1;
      if (tlb_fill_q == TLB_IDX_W'(TLB_ENTRIES - 1)) begin
        tlb_fill_q <= '0;
      end else begin
        tlb_fill_q <= tlb_fill_q + TLB_IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.resolve && miss) begin
      tlb_page_q[tlb_fill_q]  <= page;
      tlb_frame_q[tlb_fill_q] <= frame;
    end
  end

  assign status_o.out_room = !out_valid_o || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (cmd_i.resolve) begin
      out_valid_o <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.resolve) begin
      physical_address_o <= ADDR_W'({frame, offset});
      tlb_hit_o          <= hit_q;
      page_fault_o       <= fault;
      evicted_valid_o    <= ev_valid;
      evicted_page_o     <= EV_PAGE_W'(ev_page);
    end
  end

endmodule

// ----- sv/tptr_checker.sv -----
// Port-level checks for the translator and the bind that attaches them to
// tlb_page_table_translator. Depends on tptr_pkg for widths.
module tptr_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_stall_o,
  input logic                           out_valid_o,
  input logic                           out_stall_i,
  input logic [tptr_pkg::ADDR_W-1:0]    physical_address_o,
  input logic                           tlb_hit_o,
  input logic                           page_fault_o,
  input logic                           evicted_valid_o,
  input logic [tptr_pkg::EV_PAGE_W-1:0] evicted_page_o
);
  import tptr_pkg::*;

  // A stalled result item stays valid, with address, hit and fault unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(physical_address_o)
      && $stable(tlb_hit_o) && $stable(page_fault_o))
    else $error("stalled result item changed");

  // An accepted item keeps the input side busy while it is worked on.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input accepted again while busy");

  // A fault only happens on a TLB miss.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && page_fault_o |-> !tlb_hit_o)
    else $error("page fault reported on a TLB hit");

  // An eviction needs a fault, and no eviction reports page zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (evicted_valid_o && page_fault_o)
      || (!evicted_valid_o && (evicted_page_o == '0)))
    else $error("inconsistent eviction report");

endmodule

bind tlb_page_table_translator tptr_checker u_tptr_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .in_valid_i         (in_valid_i),
  .in_stall_o         (in_stall_o),
  .out_valid_o        (out_valid_o),
  .out_stall_i        (out_stall_i),
  .physical_address_o (physical_address_o),
  .tlb_hit_o          (tlb_hit_o),
  .page_fault_o       (page_fault_o),
  .evicted_valid_o    (evicted_valid_o),
  .evicted_page_o     (evicted_page_o)
);
